// ===== rtl/half_float_converter_core_assert.svh =====
// Assertion macros for the half float converter RTL.
`ifndef HALF_FLOAT_CONVERTER_CORE_ASSERT_SVH
`define HALF_FLOAT_CONVERTER_CORE_ASSERT_SVH

`ifndef SYNTH
// Check a property on clk, skipped while reset is asserted.
`define HFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("half float converter check failed");
// Check a property on clk, also while reset is asserted.
`define HFC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("half float converter check failed");
`else
`define HFC_ASSERT(lbl, prop)
`define HFC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/hfc_pkg.sv =====
// Package with command codes and the half format conversion functions.
package hfc_pkg;

  typedef enum logic [2:0] {
    CMD_PACK_HALF   = 3'd0,
    CMD_UNPACK_HALF = 3'd1,
    CMD_PACK11      = 3'd2,
    CMD_PACK10      = 3'd3,
    CMD_UNPACK11    = 3'd4,
    CMD_UNPACK10    = 3'd5
  } hfc_cmd_t;

  localparam logic [31:0] ROUND_ADD     = 32'h0000_1000;
  localparam logic [23:0] SUBNORM_BIAS  = 24'h7F_F000;
  localparam logic [14:0] MAG_SATURATE  = 15'h7FFF;
  localparam logic [8:0]  EXP_SAT_LIMIT = 9'd143;
  localparam logic [8:0]  EXP_NORM_MIN  = 9'd112;
  localparam logic [8:0]  EXP_SUB_MIN   = 9'd101;
  localparam logic [8:0]  SUB_SHIFT_TOP = 9'd125;
  localparam logic [7:0]  UNPACK_BIAS   = 8'd112;
  localparam logic [7:0]  SUBNORM_EXP   = 8'd103;

  // Pack float32 bits into a 1-5-10 half code without infinity.
  function automatic logic [15:0] pack_half_code(input logic [31:0] x);
    logic [31:0] b;
    logic [8:0]  e;
    logic [22:0] m;
    logic [23:0] sum;
    logic [4:0]  sh;
    logic [23:0] shd;
    logic [23:0] rnd;
    logic [14:0] mag;
    b   = {1'b0, x[30:0]} + ROUND_ADD;
    e   = b[31:23];
    m   = b[22:0];
    sum = SUBNORM_BIAS + {1'b0, m};
    sh  = 5'(SUB_SHIFT_TOP - e);
    shd = sum >> sh;
    rnd = (shd + 24'd1) >> 1;
    if (e > EXP_SAT_LIMIT) begin
      mag = MAG_SATURATE;
    end else if (e > EXP_NORM_MIN) begin
      mag = {5'(e - EXP_NORM_MIN), m[22:13]};
    end else if (e > EXP_SUB_MIN) begin
      mag = rnd[14:0];
    end else begin
      mag = '0;
    end
    return {x[31], mag};
  endfunction

  // Unpack a half code into float32 bits; normalize subnormals.
  function automatic logic [31:0] unpack_half_bits(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  k;
    logic [3:0]  lsh;
    logic [9:0]  ms;
    logic [7:0]  ex;
    logic [31:0] r;
    e  = h[14:10];
    m  = h[9:0];
    k  = '0;
    // Find the leading one; the highest set bit wins.
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        k = 4'(i);
      end
    end
    lsh = 4'd10 - k;
    ms  = m << lsh;
    ex  = {3'b0, e} + UNPACK_BIAS;
    if (e != 5'd0) begin
      r = {h[15], ex, m, 13'b0};
    end else if (m == 10'd0) begin
      r = {h[15], 31'b0};
    end else begin
      r = {h[15], SUBNORM_EXP + {4'b0, k}, ms, 13'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/half_float_converter_core.sv =====
// An accepted transaction goes from the input register, through the conversion
// logic, into the result register that drives out_valid. Throughput: one
// transaction per cycle while out_stall is low, set by those two registers.
// in_stall rises only when both registers hold data and out_stall is high.
// Reset (rst_n low, synchronous) empties both stages; no data is kept.
`include "half_float_converter_core_assert.svh"
module half_float_converter_core import hfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_converted,
  output logic        out_negative_error
);

  logic        s1_valid_r;
  logic [2:0]  s1_command_r;
  logic [31:0] s1_operand_r;
  logic        out_valid_r;
  logic [31:0] out_converted_r;
  logic        out_negative_error_r;

  logic        s1_valid_nxt;
  logic        out_valid_nxt;
  logic        out_ready;
  logic        s1_ready;
  logic        in_take;
  logic        s1_move;
  logic [31:0] conv_value;
  logic        conv_error;

  // Ready chain: each stage frees when its successor takes data
  assign out_ready = ~out_valid_r | ~out_stall;
  assign s1_ready  = ~s1_valid_r | out_ready;
  assign in_stall  = ~s1_ready;
  assign in_take   = in_valid & s1_ready;
  assign s1_move   = s1_valid_r & out_ready;

  // Convert the held transaction
  hfc_convert u_convert (
    .command        (s1_command_r),
    .operand        (s1_operand_r),
    .converted      (conv_value),
    .negative_error (conv_error)
  );

  // Next valid for both stages
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = in_valid;
    end
    if (out_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture payload; hold while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command_r <= in_command;
      s1_operand_r <= in_operand;
    end
    if (s1_move) begin
      out_converted_r      <= conv_value;
      out_negative_error_r <= conv_error;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_converted      = out_converted_r;
  assign out_negative_error = out_negative_error_r;

  `HFC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!s1_valid_r && !out_valid_r))
  `HFC_ASSERT(a_take_fills_s1, (in_valid && !in_stall) |=> s1_valid_r)
  `HFC_ASSERT(a_move_fills_out, s1_move |=> out_valid_r)
  `HFC_ASSERT(a_stall_only_when_full, in_stall |-> (s1_valid_r && out_valid_r && out_stall))
  `HFC_ASSERT(a_error_zero_code, (out_valid_r && out_negative_error_r) |-> (out_converted_r == 32'd0))

endmodule

// ===== rtl/hfc_convert.sv =====
// Combinational command decode and format conversion for one transaction.
module hfc_convert import hfc_pkg::*; (
  input  logic [2:0]  command,
  input  logic [31:0] operand,
  output logic [31:0] converted,
  output logic        negative_error
);

  logic        neg;
  logic [15:0] half_code;

  assign neg       = operand[31] & (|operand[30:0]);
  assign half_code = pack_half_code(operand);

  // Select the conversion for the command; unused codes give zero
  always_comb begin
    converted      = '0;
    negative_error = 1'b0;
    case (command)
      CMD_PACK_HALF: begin
        converted = {16'b0, half_code};
      end
      CMD_UNPACK_HALF: begin
        converted = unpack_half_bits(operand[15:0]);
      end
      CMD_PACK11: begin
        if (neg) begin
          negative_error = 1'b1;
        end else begin
          converted = {21'b0, half_code[14:4]};
        end
      end
      CMD_PACK10: begin
        if (neg) begin
          negative_error = 1'b1;
        end else begin
          converted = {22'b0, half_code[14:5]};
        end
      end
      CMD_UNPACK11: begin
        converted = unpack_half_bits({1'b0, operand[10:0], 4'b0});
      end
      CMD_UNPACK10: begin
        converted = unpack_half_bits({1'b0, operand[9:0], 5'b0});
      end
      default: begin
        converted      = '0;
        negative_error = 1'b0;
      end
    endcase
  end

endmodule
